FILE: hdl/bia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_pkg
// Shared codes and controller/datapath interface types of the ID allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_GET     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CHECK   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  localparam int ID_IN_W  = 16;
  localparam int CFG_W    = 9;
  localparam int GRANT_W  = 8;
  localparam int OUT_W    = 16;
  localparam int IN_USER_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // latch the accepted input word
    logic rd;     // read the free-map word at the current address
    logic eval;   // evaluate the word that was read and update the map
    logic step;   // move the scan to the next word
    logic push;   // hand the result to the output register
  } bia_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_ram;   // the latched request must touch the free map
    logic keep_scan;  // a get found nothing in this word and words remain
    logic out_busy;   // the output register holds a word not yet taken
  } bia_stat_t;

endpackage
`default_nettype wire

FILE: hdl/bia_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bia_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_ctrl
// Sequencer of the ID allocator: accept, read, evaluate, deliver.
// ----------------------------------------------------------------------------
module bia_ctrl
  import bia_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire bia_stat_t stat,
  output bia_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.need_ram) begin
          cmd.rd     = 1'b1;
          state_next = S_EVAL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.keep_scan) begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bia_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_dp
// Datapath of the ID allocator: ID count, free-map RAM, word valid bits,
// lowest-free search over one word, result and output registers.
// ----------------------------------------------------------------------------
module bia_dp
  import bia_pkg::*;
#(
  parameter int MAX_IDS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [IN_USER_W-1:0] s_tuser,
  input  wire logic [ID_IN_W-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [OUT_W-1:0]     m_tdata,
  input  wire bia_cmd_t             cmd,
  output bia_stat_t                 stat
);

  localparam int WORD_W = (MAX_IDS < 64) ? MAX_IDS : 64;
  localparam int NWORDS = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int CNT_W  = $clog2(MAX_IDS + 1);
  localparam int RST_CNT = (MAX_IDS < 256) ? MAX_IDS : 256;

  logic [CNT_W-1:0]  count;
  logic [NWORDS-1:0] wvalid;
  logic [ACT_W-1:0]  act;
  logic              in_range;
  logic [BIT_W-1:0]  bitsel;
  logic [WIDX_W-1:0] addr;
  logic              rvalid;
  logic [WORD_W-1:0] rdata;

  logic [GRANT_W-1:0] res_granted;
  logic               res_ok;
  logic               res_free;

  logic [CNT_W-1:0]  cnt_m1;
  logic [WIDX_W-1:0] last_w;
  logic [BIT_W-1:0]  last_b;
  logic [WORD_W-1:0] word_eff;
  logic [WORD_W-1:0] word_avail;
  logic              found;
  logic [BIT_W-1:0]  pos;
  logic [ID_IN_W-1:0] gid;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic              is_get;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= CNT_W'(RST_CNT);
      wvalid <= '0;
    end else if (cfg_we) begin
      // A new count frees every ID: all words fall back to their reset value.
      if (32'(cfg_wdata) > MAX_IDS) begin
        count <= CNT_W'(MAX_IDS);
      end else begin
        count <= CNT_W'(cfg_wdata);
      end
      wvalid <= '0;
    end else if (wr_en) begin
      wvalid[addr] <= 1'b1;
    end
  end

  assign is_get = (act == ACT_GET);
  assign cnt_m1 = count - CNT_W'(1);
  assign last_w = WIDX_W'(cnt_m1 >> BIT_W);
  assign last_b = cnt_m1[BIT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= s_tuser[ACT_W-1:0];
      in_range <= (s_tdata < ID_IN_W'(count));
      bitsel   <= s_tdata[BIT_W-1:0];
      if (s_tuser[ACT_W-1:0] == ACT_GET) begin
        addr <= '0;
      end else begin
        addr <= WIDX_W'(s_tdata >> BIT_W);
      end
    end else if (cmd.step) begin
      addr <= addr + WIDX_W'(1);
    end
    if (cmd.rd) begin
      rvalid <= wvalid[addr];
    end
  end

  bia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (wr_data),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (rdata)
  );

  // A word never written since the last clear reads as all free.
  assign word_eff = rvalid ? rdata : '1;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      word_avail[b] = word_eff[b] && ((addr != last_w) || (BIT_W'(b) <= last_b));
    end
  end

  // Lowest set bit of the available word.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (word_avail[b]) begin
        found = 1'b1;
        pos   = BIT_W'(b);
      end
    end
  end

  assign gid = (ID_IN_W'(addr) << BIT_W) | ID_IN_W'(pos);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = word_eff;
    if (cmd.eval) begin
      if (is_get && found) begin
        wr_en   = 1'b1;
        wr_data = word_eff & ~(WORD_W'(1) << pos);
      end else if (act == ACT_RELEASE) begin
        wr_en   = 1'b1;
        wr_data = word_eff | (WORD_W'(1) << bitsel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_granted <= '0;
      res_ok      <= 1'b0;
      res_free    <= 1'b0;
    end else if (cmd.eval) begin
      if (is_get && found) begin
        res_granted <= gid[GRANT_W-1:0];
        res_ok      <= 1'b1;
      end
      if (act == ACT_CHECK) begin
        res_free <= word_eff[bitsel];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= {(OUT_W - GRANT_W - 2)'(0), res_free, res_ok, res_granted};
    end
  end

  assign stat.need_ram  = (is_get && (count != '0)) ||
                          (((act == ACT_CHECK) || (act == ACT_RELEASE)) && in_range);
  assign stat.keep_scan = is_get && !found && (addr != last_w);
  assign stat.out_busy  = m_tvalid && !m_tready;

endmodule
`default_nettype wire

FILE: hdl/bitmap_id_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// From acceptance, a get reads and evaluates map words in turn from word 0 until
// it finds a free ID or has evaluated the last word in use; an in-range check or
// release reads and evaluates its own word once, and any other word (a zero count
// included) goes straight to the result. A new word is taken in the cycle after the
// result is loaded; a stalled output holds the result, and so the next word, back.
// Reset (synchronous, active high) sets the count to 256, capped at MAX_IDS, and
// marks every ID free at once through word valid bits.
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Lowest-free ID allocator with get, check and release requests.
// ----------------------------------------------------------------------------
module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int MAX_IDS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_wdata,   // total_ids
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [ID_IN_W-1:0]   s_tdata,     // [15:0] id_number
  input  wire logic [IN_USER_W-1:0] s_tuser,     // [1:0] action, [7:2] zero
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [OUT_W-1:0]     m_tdata      // [7:0] granted_id, [8] grant_ok,
                                                 // [9] id_free, [15:10] zero
);

  bia_cmd_t  cmd;
  bia_stat_t stat;

  bia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bia_dp #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  // A result never reports both a grant and a free check.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
    else $error("grant and check flags set together");

  // A granted ID is zero unless the grant succeeded.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == '0))
    else $error("nonzero granted ID without grant");

  // The map is only read or evaluated while an accepted word is in work.
  a_busy_work: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd || cmd.eval || cmd.push) |-> !s_tready)
    else $error("map access while idle");

  // A pushed result appears on the output in the next cycle.
  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> m_tvalid)
    else $error("pushed result not presented");

endmodule
`default_nettype wire

FILE: sim/bitmap_id_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator_test
// Self-checking bench for the lowest-free ID allocator. A directed part covers
// reset defaults, a zero count, a two-entry pool, a full pool and an
// oversized count. Random get/check/release traffic follows across several
// pool sizes, with random idling on both ports, one long output hold-off and
// drain pauses. Each result word is checked against a bit-map predictor.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_test;
  import bia_pkg::*;

  localparam int ID_SLOTS = 256;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [GRANT_W-1:0] granted;
    logic               ok;
    logic               free;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ID_IN_W-1:0]   s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  // Predictor state: one bit per ID, 1 = free.
  logic [ID_SLOTS-1:0] free_bits = '1;
  int                  id_count = ID_SLOTS;
  int                  held_ids[$];
  alloc_result_t       pending_results[$];

  int  fault_count = 0;
  int  cycles = 0;
  int  hold_asked = 0;
  int  hold_done = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;

  bitmap_id_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_id_allocator_test: errors");
      $finish;
    end
  end

  // Output side: random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fault_count <= fault_count + 1;
        if (fault_count < 10)
          $display("unexpected result word %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.granted || m_tdata[8] !== want.ok ||
            m_tdata[9] !== want.free) begin
          fault_count <= fault_count + 1;
          if (fault_count < 10)
            $display("mismatch: granted %0d/%0d ok %0b/%0b free %0b/%0b (exp/act)",
                     want.granted, m_tdata[7:0], want.ok, m_tdata[8],
                     want.free, m_tdata[9]);
        end
      end
    end
  end

  function automatic alloc_result_t predict_alloc(logic [ACT_W-1:0] act,
                                                  logic [ID_IN_W-1:0] id);
    alloc_result_t r;
    bit found;
    r = '0;
    found = 1'b0;
    case (act)
      ACT_GET: begin
        for (int i = 0; i < id_count; i++) begin
          if (!found && free_bits[i]) begin
            free_bits[i] = 1'b0;
            r.granted = i[GRANT_W-1:0];
            r.ok = 1'b1;
            found = 1'b1;
          end
        end
      end
      ACT_CHECK: begin
        if (id < id_count)
          r.free = free_bits[id[7:0]];
      end
      ACT_RELEASE: begin
        if (id < id_count)
          free_bits[id[7:0]] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one request word and returns at the edge where it is taken.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [ID_IN_W-1:0] id);
    alloc_result_t r;
    r = predict_alloc(act, id);
    if (act == ACT_GET && r.ok)
      held_ids.insert(held_ids.size(), int'(r.granted));
    pending_results.insert(pending_results.size(), r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    s_tuser  <= {{(IN_USER_W-ACT_W){1'b0}}, act};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_id_count(input logic [CFG_W-1:0] value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    id_count = (value > ID_SLOTS) ? ID_SLOTS : int'(value);
    free_bits = '1;
    held_ids.delete();
  endtask

  // Random traffic; releases mostly return IDs that were handed out.
  task automatic run_mixed_traffic(input int get_pct, input int words);
    int roll;
    int idx;
    logic [ACT_W-1:0] act;
    logic [ID_IN_W-1:0] id;
    for (int n = 0; n < words; n++) begin
      roll = $urandom_range(0, 99);
      id = (id_count == 0) ? '0 : ID_IN_W'($urandom_range(0, id_count - 1));
      if (roll < get_pct) begin
        act = ACT_GET;
        id = ID_IN_W'($urandom_range(0, 65535));
      end else if (roll < get_pct + (95 - get_pct) / 2) begin
        act = ACT_RELEASE;
        if (held_ids.size() > 0 && $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, held_ids.size() - 1);
          id = ID_IN_W'(held_ids[idx]);
          held_ids.delete(idx);
        end
      end else if (roll < 95) begin
        act = ACT_CHECK;
      end else begin
        act = ACT_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0)
          id = ID_IN_W'($urandom_range(0, 65535));
        else
          id = ID_IN_W'(id_count + $urandom_range(0, 3));
      end
      send_word(act, id);
    end
  endtask

  task automatic test_reset_defaults();
    send_word(ACT_GET, 16'hFFFF);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_CHECK, 16'd1);
    send_word(ACT_CHECK, 16'd2);
    send_word(ACT_CHECK, 16'd255);
    send_word(ACT_CHECK, 16'd256);
    send_word(ACT_CHECK, 16'hFFFF);
    send_word(ACT_RELEASE, 16'd0);
    send_word(ACT_CHECK, 16'd0);
    // Releasing an ID that is already free leaves it free.
    send_word(ACT_RELEASE, 16'd0);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_RELEASE, 16'hFFFF);
    send_word(ACT_RELEASE, 16'd256);
    send_word(ACT_UNUSED, 16'd5);
    send_word(ACT_UNUSED, 16'hFFFF);
  endtask

  task automatic test_zero_count();
    set_id_count(9'd0);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_CHECK, 16'd0);
    send_word(ACT_RELEASE, 16'd0);
    send_word(ACT_GET, 16'd0);
  endtask

  task automatic test_two_ids();
    set_id_count(9'd2);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_RELEASE, 16'd1);
    send_word(ACT_CHECK, 16'd1);
    send_word(ACT_GET, 16'd0);
  endtask

  // A count above the map size saturates; fill every word, then reopen holes.
  task automatic test_full_pool();
    set_id_count(9'd511);
    repeat (ID_SLOTS) send_word(ACT_GET, ID_IN_W'($urandom_range(0, 65535)));
    send_word(ACT_GET, 16'd0);
    send_word(ACT_CHECK, 16'd255);
    send_word(ACT_RELEASE, 16'd131);
    send_word(ACT_RELEASE, 16'd63);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_GET, 16'd0);
    send_word(ACT_GET, 16'd0);
  endtask

  task automatic test_small_pools();
    set_id_count(9'd1);
    run_mixed_traffic(50, 20);
    repeat (3) begin
      set_id_count(CFG_W'($urandom_range(3, 70)));
      run_mixed_traffic(55, 40);
    end
    set_id_count(9'd256);
    run_mixed_traffic(50, 120);
  endtask

  // The output stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    set_id_count(CFG_W'($urandom_range(65, 256)));
    hold_asked = hold_asked + 1;
    run_mixed_traffic(60, 120);
  endtask

  task automatic test_drain_pause();
    set_id_count(9'd65);
    repeat (4) begin
      run_mixed_traffic(50, 30);
      wait_drain();
    end
  endtask

  task automatic test_final_burst();
    set_id_count(9'd130);
    quiet = 1'b1;
    run_mixed_traffic(60, 150);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_count();
    test_two_ids();
    test_full_pool();
    test_small_pools();
    test_backpressure();
    test_drain_pause();
    test_final_burst();
    wait_drain();
    if (fault_count == 0) begin
      $display("bitmap_id_allocator_test: clean");
    end else begin
      $display("bitmap_id_allocator_test: errors");
    end
    $finish;
  end

endmodule
